// ===== design/battery_level_estimator_core_macros.svh =====
// assertion macros shared by the battery level estimator rtl
`ifndef BATTERY_LEVEL_ESTIMATOR_CORE_MACROS_SVH
`define BATTERY_LEVEL_ESTIMATOR_CORE_MACROS_SVH

// clocked on aclk, off while aresetn is low
`define BLEST_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked on aclk, also checked during reset
`define BLEST_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/blest_pkg.sv =====
// types, constants and curve tables of the battery level estimator
package blest_pkg;

    localparam int RawW    = 16;
    localparam int MvFullW = 15;
    localparam int MvW     = 13;
    localparam int PctW    = 7;
    localparam int DpW     = 4;
    localparam int DeltaW  = 8;
    localparam int ProdW   = 12;
    localparam int SegW    = 4;
    localparam int RecipW  = 17;
    localparam int RecipShift = 22;
    localparam int ScaledW = ProdW + RecipW;
    localparam int IdxW    = 5;
    localparam int LastPoint = 16;
    localparam int PaddrW  = 3;
    localparam int PdataW  = 32;

    localparam logic [MvFullW-1:0] MvMin = 15'd2500;
    localparam logic [MvFullW-1:0] MvMax = 15'd5000;
    localparam logic [PctW:0]      ChargeMax = 8'd100;

    // register index, taken from paddr[2]
    localparam logic RegGaugePresent = 1'b0;

    typedef struct packed {
        logic [15:0] cell_voltage_raw;
        logic        voltage_read_ok;
        logic [7:0]  charge_byte;
        logic        charge_read_ok;
    } blest_in_t;

    typedef struct packed {
        logic        level_valid;
        logic [6:0]  level_percent;
        logic        from_voltage_curve;
    } blest_out_t;

    typedef struct packed {
        logic            ok;
        logic            curve;
        logic [PctW-1:0] chg;
        logic [MvW-1:0]  mv;
    } blest_s1_t;

    typedef struct packed {
        logic              ok;
        logic              curve;
        logic [PctW-1:0]   base;
        logic [DpW-1:0]    dp;
        logic [DeltaW-1:0] delta;
        logic [SegW-1:0]   seg;
    } blest_s2_t;

    typedef struct packed {
        logic             ok;
        logic             curve;
        logic [PctW-1:0]  base;
        logic [SegW-1:0]  seg;
        logic [ProdW-1:0] prod;
    } blest_s3_t;

    function automatic logic [MvW-1:0] curve_mv(input logic [IdxW-1:0] idx);
        logic [MvW-1:0] v;
        case (idx)
            5'd0:    v = 13'd4200;
            5'd1:    v = 13'd4080;
            5'd2:    v = 13'd4000;
            5'd3:    v = 13'd3920;
            5'd4:    v = 13'd3840;
            5'd5:    v = 13'd3760;
            5'd6:    v = 13'd3700;
            5'd7:    v = 13'd3650;
            5'd8:    v = 13'd3600;
            5'd9:    v = 13'd3550;
            5'd10:   v = 13'd3500;
            5'd11:   v = 13'd3450;
            5'd12:   v = 13'd3400;
            5'd13:   v = 13'd3350;
            5'd14:   v = 13'd3300;
            5'd15:   v = 13'd3200;
            5'd16:   v = 13'd3000;
            default: v = 13'd3000;
        endcase
        return v;
    endfunction

    function automatic logic [PctW-1:0] curve_pct(input logic [IdxW-1:0] idx);
        logic [PctW-1:0] p;
        case (idx)
            5'd0:    p = 7'd100;
            5'd1:    p = 7'd90;
            5'd2:    p = 7'd80;
            5'd3:    p = 7'd70;
            5'd4:    p = 7'd60;
            5'd5:    p = 7'd50;
            5'd6:    p = 7'd40;
            5'd7:    p = 7'd30;
            5'd8:    p = 7'd22;
            5'd9:    p = 7'd18;
            5'd10:   p = 7'd14;
            5'd11:   p = 7'd11;
            5'd12:   p = 7'd8;
            5'd13:   p = 7'd6;
            5'd14:   p = 7'd4;
            5'd15:   p = 7'd2;
            5'd16:   p = 7'd1;
            default: p = 7'd1;
        endcase
        return p;
    endfunction

    // ceil(2^22 / segment width in mv), exact quotient for products below 4096
    function automatic logic [RecipW-1:0] seg_recip(input logic [SegW-1:0] seg);
        logic [RecipW-1:0] r;
        case (seg)
            4'd0:    r = 17'd34953;
            4'd1:    r = 17'd52429;
            4'd2:    r = 17'd52429;
            4'd3:    r = 17'd52429;
            4'd4:    r = 17'd52429;
            4'd5:    r = 17'd69906;
            4'd14:   r = 17'd41944;
            4'd15:   r = 17'd20972;
            default: r = 17'd83887;
        endcase
        return r;
    endfunction

endpackage

// ===== design/battery_level_estimator_core.sv =====
// battery level estimator top level: apb register and four-stage pipeline
//
// s_valid/s_ready/s_item carry one fuel-gauge reading per item; m_valid/m_ready/m_item
// return one level item for every reading, in order.
// the apb port holds gauge_present at byte address 0; pready is always high and a
// write lands at the access cycle. change it only while the pipeline is empty.
// a reading is registered in stages 1, 2 and 3 and then in the result register before
// it shows on m_valid. throughput: one item per cycle while m_ready is high; every
// stage is a register with its own valid bit.
// stage 1 converts to millivolts and qualifies, stage 2 finds the curve segment,
// stage 3 forms the slope product, stage 4 divides by the segment width through a
// reciprocal multiply and holds the result.
// when m_ready is low the result holds and the stages fill behind it; s_ready falls
// only once every stage is full, and picks up again as soon as m_ready returns.
// reset clears every valid bit and sets gauge_present to 0, so until it is written
// each reading gives an item with level_valid low.
`include "battery_level_estimator_core_macros.svh"

module battery_level_estimator_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [blest_pkg::PaddrW-1:0] paddr,
    input  logic [blest_pkg::PdataW-1:0] pwdata,
    output logic [blest_pkg::PdataW-1:0] prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  blest_pkg::blest_in_t         s_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output blest_pkg::blest_out_t        m_item
);
    import blest_pkg::*;

    logic      gauge_present;
    logic      s1_valid;
    logic      s1_ready;
    blest_s1_t s1_data;
    logic      s2_valid;
    logic      s2_ready;
    blest_s2_t s2_data;

    blest_regs u_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .gauge_present (gauge_present)
    );

    blest_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .gauge_present (gauge_present),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_item       (s_item),
        .out_valid     (s1_valid),
        .out_ready     (s1_ready),
        .out_data      (s1_data)
    );

    blest_seg u_seg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    blest_interp u_interp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (m_item)
    );

    // an invalid level carries zero percent and no curve flag
    `BLEST_ASSERT(a_invalid_zero, (m_valid && !m_item.level_valid |-> m_item.level_percent == '0 && !m_item.from_voltage_curve), "invalid level item carries nonzero fields")

    // a level from the curve is always between 1 and 100
    `BLEST_ASSERT(a_curve_range, (m_valid && m_item.from_voltage_curve |-> m_item.level_valid && m_item.level_percent >= 7'd1 && m_item.level_percent <= 7'd100), "curve level out of range")

    // the pipeline never holds off readings while the result side can drain
    `BLEST_ASSERT(a_no_bubble_stall, ((m_ready || !m_valid) |-> s_ready), "input stalled with room in the pipeline")

    // the register readback shows nothing above bit 0
    `BLEST_ASSERT_ALWAYS(a_prdata_upper, (prdata[PdataW-1:1] == '0), "register readback has stray bits")

endmodule

// ===== design/blest_regs.sv =====
// apb configuration register holding the gauge present flag
module blest_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [blest_pkg::PaddrW-1:0] paddr,
    input  logic [blest_pkg::PdataW-1:0] pwdata,
    output logic [blest_pkg::PdataW-1:0] prdata,
    output logic                        pready,
    output logic                        gauge_present
);
    import blest_pkg::*;

    logic gauge_present_reg;
    logic gauge_present_next;
    logic wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == RegGaugePresent);

    always_comb begin
        gauge_present_next = gauge_present_reg;
        if (wr_hit) begin
            gauge_present_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gauge_present_reg <= 1'b0;
        end else begin
            gauge_present_reg <= gauge_present_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == RegGaugePresent) begin
            prdata[0] = gauge_present_reg;
        end
    end

    assign gauge_present = gauge_present_reg;

endmodule

// ===== design/blest_front.sv =====
// first stage: raw word to millivolts, range check and source choice
module blest_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 gauge_present,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  blest_pkg::blest_in_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output blest_pkg::blest_s1_t out_data
);
    import blest_pkg::*;

    logic                    valid_reg;
    logic                    valid_next;
    blest_s1_t               data_reg;
    blest_s1_t               data_next;
    logic [RawW+2:0]         times5;
    logic [MvFullW-1:0]      mv_full;
    logic                    in_range;
    logic                    ok;
    logic                    use_chg;

    // raw * 3125 / 10000 is exactly raw * 5 / 16
    assign times5  = {1'b0, in_item.cell_voltage_raw, 2'b00}
                   + {3'b000, in_item.cell_voltage_raw};
    assign mv_full = times5[RawW+2:4];
    assign in_range = (mv_full >= MvMin) && (mv_full <= MvMax);
    assign ok       = gauge_present && in_item.voltage_read_ok && in_range;
    assign use_chg  = in_item.charge_read_ok && ({1'b0, in_item.charge_byte} <= {1'b0, ChargeMax});

    always_comb begin
        data_next.ok    = ok;
        data_next.curve = ok && !use_chg;
        data_next.chg   = (ok && use_chg) ? in_item.charge_byte[PctW-1:0] : '0;
        data_next.mv    = mv_full[MvW-1:0];
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/blest_seg.sv =====
// second stage: curve segment search, base level and offset into the segment
module blest_seg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  blest_pkg::blest_s1_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output blest_pkg::blest_s2_t out_data
);
    import blest_pkg::*;

    logic            valid_reg;
    logic            valid_next;
    blest_s2_t       data_reg;
    blest_s2_t       data_next;
    logic [IdxW-1:0] k_hit;
    logic [IdxW-1:0] k_prev;
    logic            hit;
    logic            top;
    logic [PctW-1:0] pct_hi;
    logic [PctW-1:0] pct_lo;

    // parallel compares; walking down means the lowest-index point at or below mv wins
    always_comb begin
        k_hit = '0;
        hit   = 1'b0;
        for (int k = LastPoint; k >= 1; k--) begin
            if (in_data.mv >= curve_mv(IdxW'(k))) begin
                k_hit = IdxW'(k);
                hit   = 1'b1;
            end
        end
    end

    assign top    = in_data.mv >= curve_mv('0);
    assign k_prev = k_hit - IdxW'(1);
    assign pct_hi = curve_pct(k_prev);
    assign pct_lo = curve_pct(k_hit);

    always_comb begin
        data_next.ok    = in_data.ok;
        data_next.curve = in_data.curve;
        data_next.base  = in_data.chg;
        data_next.dp    = '0;
        data_next.delta = '0;
        data_next.seg   = '0;
        if (in_data.curve) begin
            if (top) begin
                data_next.base = curve_pct('0);
            end else if (!hit) begin
                data_next.base = curve_pct(IdxW'(LastPoint));
            end else begin
                data_next.base  = pct_lo;
                data_next.dp    = DpW'(pct_hi - pct_lo);
                data_next.delta = DeltaW'(in_data.mv - curve_mv(k_hit));
                data_next.seg   = k_prev[SegW-1:0];
            end
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/blest_interp.sv =====
// third and fourth stages: slope product, reciprocal divide and result register
module blest_interp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  blest_pkg::blest_s2_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output blest_pkg::blest_out_t out_item
);
    import blest_pkg::*;

    logic             s3_valid_reg;
    logic             s3_valid_next;
    blest_s3_t        s3_reg;
    blest_s3_t        s3_next;
    logic             s3_ready;
    logic             out_valid_reg;
    logic             out_valid_next;
    blest_out_t       out_reg;
    blest_out_t       out_next;
    logic [ScaledW-1:0] scaled;
    logic [PctW-1:0]  quot;

    always_comb begin
        s3_next.ok    = in_data.ok;
        s3_next.curve = in_data.curve;
        s3_next.base  = in_data.base;
        s3_next.seg   = in_data.seg;
        s3_next.prod  = ProdW'({{(ProdW-DpW){1'b0}}, in_data.dp}
                             * {{(ProdW-DeltaW){1'b0}}, in_data.delta});
    end

    // division by the segment width as multiply by its reciprocal
    assign scaled = ScaledW'(s3_reg.prod) * ScaledW'(seg_recip(s3_reg.seg));
    assign quot   = scaled[RecipShift +: PctW];

    always_comb begin
        out_next.level_valid        = s3_reg.ok;
        out_next.level_percent      = s3_reg.base + quot;
        out_next.from_voltage_curve = s3_reg.curve;
    end

    assign s3_ready       = !out_valid_reg || out_ready;
    assign in_ready       = !s3_valid_reg || s3_ready;
    assign s3_valid_next  = in_ready ? in_valid : s3_valid_reg;
    assign out_valid_next = s3_ready ? s3_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            s3_reg <= s3_next;
        end
        if (s3_valid_reg && s3_ready) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== tb/tb_top.sv =====
// testbench for the battery level estimator: gauge readings in, level items checked in order
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import blest_pkg::*;

    localparam int CycleLimit  = 200000;
    localparam int HoldCycles  = 120;
    localparam int DrainCycles = 8;

    // expected level items, predicted from each accepted reading
    class level_scoreboard;
        blest_out_t level_q[$];
        int errors;
        int checked;

        function int unsigned curve_percent(int unsigned mv);
            int unsigned knee_mv[17] = '{4200, 4080, 4000, 3920, 3840, 3760, 3700, 3650, 3600,
                                         3550, 3500, 3450, 3400, 3350, 3300, 3200, 3000};
            int unsigned knee_pct[17] = '{100, 90, 80, 70, 60, 50, 40, 30, 22,
                                          18, 14, 11, 8, 6, 4, 2, 1};
            if (mv >= knee_mv[0])
                return knee_pct[0];
            for (int k = 1; k < 17; k++) begin
                if (mv >= knee_mv[k])
                    return knee_pct[k] + (knee_pct[k-1] - knee_pct[k]) * (mv - knee_mv[k])
                           / (knee_mv[k-1] - knee_mv[k]);
            end
            return 1;
        endfunction

        function blest_out_t predict_level(blest_in_t rd, bit gauge);
            int unsigned raw;
            int unsigned mv;
            blest_out_t lv;
            raw = rd.cell_voltage_raw;
            mv = raw * 3125 / 10000;
            lv = '0;
            if (gauge && rd.voltage_read_ok && mv >= 2500 && mv <= 5000) begin
                lv.level_valid = 1'b1;
                if (rd.charge_read_ok && rd.charge_byte <= 100) begin
                    lv.level_percent = rd.charge_byte[6:0];
                end else begin
                    lv.level_percent = 7'(curve_percent(mv));
                    lv.from_voltage_curve = 1'b1;
                end
            end
            return lv;
        endfunction

        function void note_reading(blest_in_t rd, bit gauge);
            level_q.push_back(predict_level(rd, gauge));
        endfunction

        function int pending();
            return level_q.size();
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_level(input blest_out_t got);
            blest_out_t want;
            if (level_q.size() == 0) begin
                report($sformatf("level item %p with no reading waiting", got));
            end else begin
                want = level_q.pop_front();
                checked++;
                if (got.level_valid !== want.level_valid)
                    report($sformatf("item %0d level_valid got %b want %b",
                                     checked, got.level_valid, want.level_valid));
                if (got.level_percent !== want.level_percent)
                    report($sformatf("item %0d level_percent got %0d want %0d",
                                     checked, got.level_percent, want.level_percent));
                if (got.from_voltage_curve !== want.from_voltage_curve)
                    report($sformatf("item %0d from_voltage_curve got %b want %b",
                                     checked, got.from_voltage_curve,
                                     want.from_voltage_curve));
            end
        endtask
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [PaddrW-1:0] paddr = '0;
    logic [PdataW-1:0] pwdata = '0;
    logic [PdataW-1:0] prdata;
    logic              pready;
    logic              s_valid = 1'b0;
    logic              s_ready;
    blest_in_t         s_item = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    blest_out_t        m_item;

    level_scoreboard sb = new();
    bit  gauge_cfg;
    bit  quiet;
    bit  rx_hold_req;
    int  cycle_count;
    int  readings_sent;
    int  cfg_writes;

    battery_level_estimator_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles, %0d levels still due", cycle_count,
                     sb.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_level(m_item);
    end

    // result side: random stalls, one long hold-off on request, none when quiet
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    function automatic blest_in_t make_reading(input logic [15:0] raw, input logic vok,
                                               input logic [7:0] chg, input logic cok);
        blest_in_t rd;
        rd.cell_voltage_raw = raw;
        rd.voltage_read_ok  = vok;
        rd.charge_byte      = chg;
        rd.charge_read_ok   = cok;
        return rd;
    endfunction

    function automatic blest_in_t random_reading();
        blest_in_t rd;
        int kind;
        int pick;
        logic [15:0] edges[10] = '{16'd7999, 16'd8000, 16'd16003, 16'd16004, 16'd13440,
                                   16'd13439, 16'd9600, 16'd9599, 16'd10560, 16'd12032};
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            // in the valid voltage band
            rd.cell_voltage_raw = 16'($urandom_range(8000, 16003));
            rd.voltage_read_ok  = ($urandom_range(0, 19) != 0);
        end else if (kind < 82) begin
            pick = $urandom_range(0, 9);
            rd.cell_voltage_raw = edges[pick] + 16'($urandom_range(0, 2)) - 16'd1;
            rd.voltage_read_ok  = ($urandom_range(0, 9) != 0);
        end else begin
            rd.cell_voltage_raw = 16'($urandom);
            rd.voltage_read_ok  = 1'($urandom);
        end
        kind = $urandom_range(0, 9);
        if (kind < 5)
            rd.charge_byte = 8'($urandom_range(0, 100));
        else if (kind < 8)
            rd.charge_byte = 8'($urandom_range(101, 255));
        else
            rd.charge_byte = 8'($urandom);
        rd.charge_read_ok = ($urandom_range(0, 3) != 0);
        return rd;
    endfunction

    // offer one reading and hold it until it is taken
    task send_reading(input blest_in_t rd);
        s_valid <= 1'b1;
        s_item  <= rd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_reading(rd, gauge_cfg);
        readings_sent++;
    endtask

    task idle_gap(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task send_random(input int n);
        for (int i = 0; i < n; i++) begin
            send_reading(random_reading());
            if (!quiet && $urandom_range(0, 7) == 0)
                idle_gap($urandom_range(1, 12));
        end
    endtask

    // stop offering and let every level item come back
    task wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task apb_write(input logic [PaddrW-1:0] addr, input logic [PdataW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr[2] == RegGaugePresent)
            gauge_cfg = data[0];
        cfg_writes++;
        @(posedge aclk);
    endtask

    task apb_check_gauge();
        logic [PdataW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== PdataW'(gauge_cfg))
            sb.report($sformatf("gauge_present read %h want %0d", got, gauge_cfg));
        @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // gauge absent after reset: no level even for a good reading
        apb_check_gauge();
        send_reading(make_reading(16'd12000, 1'b1, 8'd50, 1'b1));
        send_reading(make_reading(16'd12000, 1'b1, 8'd200, 1'b0));
        send_reading(make_reading(16'd13440, 1'b1, 8'd100, 1'b1));
        wait_drained();

        // a write past the register list must leave the gauge absent
        apb_write(PaddrW'(4), 32'hFFFF_FFFF);
        apb_check_gauge();
        send_reading(make_reading(16'd12000, 1'b1, 8'd60, 1'b1));
        wait_drained();

        apb_write(PaddrW'(0), 32'hFFFF_FFFF);
        apb_check_gauge();
        send_reading(make_reading(16'd0, 1'b1, 8'd50, 1'b1));
        send_reading(make_reading(16'd65535, 1'b1, 8'd50, 1'b1));
        send_reading(make_reading(16'd7999, 1'b1, 8'd50, 1'b1));
        send_reading(make_reading(16'd8000, 1'b1, 8'd255, 1'b1));
        send_reading(make_reading(16'd16003, 1'b1, 8'd100, 1'b1));
        send_reading(make_reading(16'd16004, 1'b1, 8'd0, 1'b1));
        send_reading(make_reading(16'd12000, 1'b0, 8'd40, 1'b1));
        send_reading(make_reading(16'd12000, 1'b1, 8'd0, 1'b1));
        send_reading(make_reading(16'd12000, 1'b1, 8'd100, 1'b0));
        send_reading(make_reading(16'd12000, 1'b1, 8'd101, 1'b1));
        send_reading(make_reading(16'd13440, 1'b1, 8'd255, 1'b0));
        send_reading(make_reading(16'd13439, 1'b1, 8'd200, 1'b1));
        send_reading(make_reading(16'd9600, 1'b1, 8'd128, 1'b1));
        send_reading(make_reading(16'd9599, 1'b1, 8'd77, 1'b0));
        send_reading(make_reading(16'd10560, 1'b1, 8'd255, 1'b1));
        send_reading(make_reading(16'd12032, 1'b1, 8'd255, 1'b1));
        send_reading(make_reading(16'd11520, 1'b1, 8'd255, 1'b1));
        send_reading(make_reading(16'd13056, 1'b1, 8'd255, 1'b1));
        send_reading(make_reading(16'd10240, 1'b1, 8'd255, 1'b1));
        send_reading(make_reading(16'd12797, 1'b1, 8'd101, 1'b0));
        idle_gap(3);

        send_random(150);
        // long hold-off on the result side while readings keep coming
        rx_hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_reading(random_reading());
        send_random(110);
        // sender waits until every level is back
        wait_drained();
        send_random(100);
        wait_drained();

        apb_write(PaddrW'(0), 32'hFFFF_FFFE);
        apb_check_gauge();
        send_random(60);
        wait_drained();

        apb_write(PaddrW'(0), 32'h0000_0001);
        apb_check_gauge();
        send_random(290);
        quiet = 1'b1;
        send_random(150);
        wait_drained();

        $display("covered %0d readings and %0d level items over %0d register writes",
                 readings_sent, sb.checked, cfg_writes);
        $display("gauge absent and present, band edges, charge byte and curve paths");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
